/* hdl/assert_macros.svh */
// Assertion macros shared by the road scanline generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RSG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rsg: assertion failed");

// Check that a condition never holds outside reset.
`define RSG_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("rsg: forbidden condition seen");

`endif

/* hdl/rsg_pkg.sv */
// Types, codes and microcode program of the road scanline generator.
`default_nettype none

package rsg_pkg;

  // Input beat: one road row.
  typedef struct packed {
    logic        mode;
    logic [14:0] depth;
  } in_t;

  // Output beat: one screen line.
  typedef struct packed {
    logic [7:0]         line;
    logic signed [15:0] hscroll;
    logic signed [7:0]  vscroll;
    logic               shade;
    logic               last;
  } out_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEG_POS    = 3'd0,
    CFG_NEAR_CURVE = 3'd1,
    CFG_NEAR_SLOPE = 3'd2,
    CFG_FAR_CURVE  = 3'd3,
    CFG_FAR_SLOPE  = 3'd4,
    CFG_SCROLL     = 3'd5
  } cfg_reg_e;

  // Datapath micro-operations.
  typedef enum logic [2:0] {
    OP_LATCH  = 3'd0,
    OP_FRAME  = 3'd1,
    OP_RATE   = 3'd2,
    OP_OFFSET = 3'd3,
    OP_DRAW   = 3'd4,
    OP_EMIT   = 3'd5,
    OP_TAIL   = 3'd6
  } uop_e;

  // Sequencing of the step counter.
  typedef enum logic [1:0] {
    SEQ_NEXT    = 2'd0,
    SEQ_WAIT_IN = 2'd1,
    SEQ_LOOP    = 2'd2,
    SEQ_JUMP    = 2'd3
  } seq_e;

  typedef enum logic [2:0] {
    STEP_WAIT   = 3'd0,
    STEP_FRAME  = 3'd1,
    STEP_RATE   = 3'd2,
    STEP_OFFSET = 3'd3,
    STEP_DRAW   = 3'd4,
    STEP_EMIT   = 3'd5,
    STEP_TAIL   = 3'd6
  } step_e;

  typedef struct packed {
    uop_e  op;
    seq_e  seq;
    step_e target;
  } uword_t;

  // Status fed back from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic count_zero;
  } useq_stat_t;

  function automatic uword_t ucode_rom(input step_e step);
    uword_t w;
    case (step)
      STEP_WAIT:   w = '{op: OP_LATCH,  seq: SEQ_WAIT_IN, target: STEP_WAIT};
      STEP_FRAME:  w = '{op: OP_FRAME,  seq: SEQ_NEXT,    target: STEP_WAIT};
      STEP_RATE:   w = '{op: OP_RATE,   seq: SEQ_NEXT,    target: STEP_WAIT};
      STEP_OFFSET: w = '{op: OP_OFFSET, seq: SEQ_NEXT,    target: STEP_WAIT};
      STEP_DRAW:   w = '{op: OP_DRAW,   seq: SEQ_NEXT,    target: STEP_WAIT};
      STEP_EMIT:   w = '{op: OP_EMIT,   seq: SEQ_LOOP,    target: STEP_TAIL};
      STEP_TAIL:   w = '{op: OP_TAIL,   seq: SEQ_JUMP,    target: STEP_WAIT};
      default:     w = '{op: OP_TAIL,   seq: SEQ_JUMP,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/rsg_useq.sv */
// Step counter and control store of the road scanline generator.
`default_nettype none

module rsg_useq import rsg_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire useq_stat_t stat_i,
  output step_e      pc_o,
  output uword_t     uword_o
);

  step_e  pc_q, pc_d, pc_inc;
  uword_t uword;

  assign uword  = ucode_rom(pc_q);
  assign pc_inc = step_e'(pc_q + 3'd1);

  always_comb begin
    pc_d = pc_q;
    case (uword.seq)
      SEQ_NEXT:    pc_d = pc_inc;
      SEQ_WAIT_IN: begin
        if (stat_i.in_valid) begin
          pc_d = pc_inc;
        end
      end
      SEQ_LOOP:    begin
        if (stat_i.count_zero) begin
          pc_d = uword.target;
        end
      end
      SEQ_JUMP:    pc_d = uword.target;
      default:     pc_d = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign pc_o    = pc_q;
  assign uword_o = uword;

endmodule

`default_nettype wire

/* hdl/road_scanline_generator.sv */
// Top level of the road scanline generator: config, datapath and output stage.
//
//   channel   direction  handshake               beat
//   in        in         in_valid_i/in_stall_o   in_t:  mode, depth
//   out       out        out_valid_o/out_stall_i out_t: line, hscroll, vscroll, shade, last
//   cfg       in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A row runs through the wait, frame, rate, offset, draw, emit and tail steps; the
// emit step repeats for each line its advance sweeps (0 to MAX_REPEAT) and holds
// while the output is stalled with a line ready. The microcode program issues one
// control word per cycle, and one swept line per cycle in the emit step unless stalled.
// Reset is asynchronous, active low; it restores config and frame state.
// A finished line waits in the output register while the next one is built.
`default_nettype none

module road_scanline_generator import rsg_pkg::*; #(
  parameter int SCREEN_LINES = 224,
  parameter int MAX_REPEAT   = 8,
  parameter int FRAC_BITS    = 10
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire in_t             in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output out_t                 out_data_o,
  input  wire                  cfg_we_i,
  input  wire  [CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [CfgDataW-1:0]  cfg_wdata_i
);

`include "assert_macros.svh"

  // Floor of the draw position needs one spare bit so a sweep below the
  // most negative line never wraps to a positive one.
  localparam int CDP_W = 33 - FRAC_BITS;
  // Width holding a clamped advance.
  localparam int AW    = FRAC_BITS + $clog2(MAX_REPEAT) + 1;
  localparam int CNT_W = $clog2(MAX_REPEAT + 1);

  localparam logic [31:0] ONE_FIX  = 32'(1 << FRAC_BITS);
  localparam logic [32:0] ADV_MAX  = 33'(MAX_REPEAT * (1 << FRAC_BITS));
  localparam logic [31:0] DRAW_RST = 32'((SCREEN_LINES - 1) * (1 << FRAC_BITS));
  localparam logic [7:0]  LINE_RST = 8'(SCREEN_LINES - 1);
  localparam logic [9:0]  SCROLL_RST = 10'h3A0;  // -96

  // Sequencer
  step_e      pc;
  uword_t     uword;
  useq_stat_t stat;

  // Configuration
  logic [14:0] seg_pos_q;
  logic [10:0] near_curve_q, near_slope_q, far_curve_q, far_slope_q;
  logic [9:0]  scroll_q;

  // Frame state
  logic [31:0] curve_q, curve_d, lat_q, lat_d, slope_q, slope_d, draw_q, draw_d;
  logic [7:0]  horizon_q, horizon_d, srow_q, srow_d;

  // Per-row working registers
  in_t              in_q, in_d;
  logic [31:0]      adv_q, adv_d;
  logic             adv_pos_q, adv_pos_d;
  logic [CDP_W-1:0] cdp_q, cdp_d;
  logic [CNT_W-1:0] count_q, count_d, cnt_w;
  logic [15:0]      hs_q, hs_d;
  logic             shade_q, shade_d;

  // Output register
  out_t out_q;
  logic out_valid_q;

  // Datapath intermediates
  logic             in_acc, near, out_free, emitting, in_range, step_go, out_load;
  logic [10:0]      dx, dy;
  logic [32:0]      adv_sum;
  logic signed [AW:0] t_s, tq_s, neg_s;
  logic [16:0]      seg_diff;

  assign in_stall_o = (pc != STEP_WAIT);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign stat.in_valid   = in_valid_i;
  assign stat.count_zero = (count_q == '0);

  rsg_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .pc_o    (pc),
    .uword_o (uword)
  );

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_pos_q    <= '0;
      near_curve_q <= '0;
      near_slope_q <= '0;
      far_curve_q  <= '0;
      far_slope_q  <= '0;
      scroll_q     <= SCROLL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEG_POS:    seg_pos_q    <= cfg_wdata_i;
        CFG_NEAR_CURVE: near_curve_q <= cfg_wdata_i[10:0];
        CFG_NEAR_SLOPE: near_slope_q <= cfg_wdata_i[10:0];
        CFG_FAR_CURVE:  far_curve_q  <= cfg_wdata_i[10:0];
        CFG_FAR_SLOPE:  far_slope_q  <= cfg_wdata_i[10:0];
        CFG_SCROLL:     scroll_q     <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // Segment choice: rows nearer than the boundary take the near segment.
  assign near = (in_q.depth < seg_pos_q);
  assign dx   = near ? near_curve_q : far_curve_q;
  assign dy   = near ? near_slope_q : far_slope_q;

  // Row advance, one line plus the accumulated slope.
  assign adv_sum = {1'b0, ONE_FIX} + {slope_q[31], slope_q};

  // Lines swept: floor(cur) - floor(cur - adv) = -floor((frac(cur) - adv) / 2^F).
  assign t_s   = $signed({1'b0, AW'(draw_q[FRAC_BITS-1:0])}) - $signed({1'b0, adv_q[AW-1:0]});
  assign tq_s  = t_s >>> FRAC_BITS;
  assign neg_s = -tq_s;
  assign cnt_w = neg_s[CNT_W-1:0];

  assign seg_diff = {2'b00, seg_pos_q} - {2'b00, in_q.depth};

  // Emit step: lines at or below the horizon and not negative go out.
  assign out_free = !out_valid_q || !out_stall_i;
  assign emitting = (uword.op == OP_EMIT) && (count_q != '0);
  assign in_range = !cdp_q[CDP_W-1] && (cdp_q <= {{(CDP_W-8){1'b0}}, horizon_q});
  assign step_go  = emitting && (!in_range || out_free);
  assign out_load = step_go && in_range;

  always_comb begin
    in_d      = in_q;
    curve_d   = curve_q;
    lat_d     = lat_q;
    slope_d   = slope_q;
    draw_d    = draw_q;
    horizon_d = horizon_q;
    srow_d    = srow_q;
    adv_d     = adv_q;
    adv_pos_d = adv_pos_q;
    cdp_d     = cdp_q;
    count_d   = count_q;
    hs_d      = hs_q;
    shade_d   = shade_q;
    case (uword.op)
      OP_LATCH: begin
        if (in_acc) begin
          in_d = in_data_i;
        end
      end
      OP_FRAME: begin
        // New frame: put the frame state back to its starting values.
        if (in_q.mode) begin
          curve_d   = '0;
          lat_d     = '0;
          slope_d   = '0;
          draw_d    = DRAW_RST;
          horizon_d = LINE_RST;
          srow_d    = LINE_RST;
        end
      end
      OP_RATE: begin
        curve_d = curve_q + {{21{dx[10]}}, dx};
        slope_d = slope_q + {{21{dy[10]}}, dy};
      end
      OP_OFFSET: begin
        lat_d     = lat_q + curve_q;
        adv_pos_d = !adv_sum[32] && (adv_sum != '0);
        // Clamp the advance to MAX_REPEAT lines.
        adv_d     = ($signed(adv_sum) > $signed(ADV_MAX)) ? ADV_MAX[31:0] : adv_sum[31:0];
      end
      OP_DRAW: begin
        draw_d  = draw_q - adv_q;
        cdp_d   = {draw_q[31], draw_q[31:FRAC_BITS]};
        count_d = adv_pos_q ? cnt_w : '0;
        hs_d    = lat_q[FRAC_BITS +: 16] + {{6{scroll_q[9]}}, scroll_q};
        shade_d = seg_diff[FRAC_BITS];
      end
      OP_EMIT: begin
        if (step_go) begin
          count_d = count_q - CNT_W'(1);
          cdp_d   = cdp_q - CDP_W'(1);
          if (in_range) begin
            horizon_d = cdp_q[7:0];
          end
        end
      end
      OP_TAIL: begin
        srow_d = srow_q - 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q   <= '0;
      lat_q     <= '0;
      slope_q   <= '0;
      draw_q    <= DRAW_RST;
      horizon_q <= LINE_RST;
      srow_q    <= LINE_RST;
      count_q   <= '0;
    end else begin
      curve_q   <= curve_d;
      lat_q     <= lat_d;
      slope_q   <= slope_d;
      draw_q    <= draw_d;
      horizon_q <= horizon_d;
      srow_q    <= srow_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    adv_q     <= adv_d;
    adv_pos_q <= adv_pos_d;
    cdp_q     <= cdp_d;
    hs_q      <= hs_d;
    shade_q   <= shade_d;
  end

  // Output register: load a line when free, drop the beat once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.line    <= cdp_q[7:0];
      out_q.hscroll <= hs_q;
      out_q.vscroll <= srow_q - cdp_q[7:0];
      out_q.shade   <= shade_q;
      // Final line of the row: sweep ends here or line zero is reached.
      out_q.last    <= (count_q == CNT_W'(1)) || (cdp_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RSG_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_REPEAT))
  `RSG_NEVER(a_accept_busy, clk_i, rst_ni, in_acc && (count_q != '0))
  `RSG_ASSERT(a_horizon_follows, clk_i, rst_ni, out_load |=> (out_q.line == horizon_q))

endmodule

`default_nettype wire
